FILE: hdl/circular_fifo_search_average_macros.svh
// Assertion shorthands used by the checker file.
`ifndef CIRCULAR_FIFO_SEARCH_AVERAGE_MACROS_SVH
`define CIRCULAR_FIFO_SEARCH_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CFSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfsa: same-cycle implication failed");

// Next-cycle implication, disabled while reset is held.
`define CFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfsa: next-cycle implication failed");

`endif

FILE: hdl/cfsa_pkg.sv
`default_nettype none

package cfsa_pkg;

  // Default sizing
  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int TIME_W  = 32;
  localparam int RPM_W   = 16;
  localparam int OTHER_W = 32;
  localparam int AVG_W   = 24;
  localparam int FILL_W  = 5;
  localparam int FRAC_W  = 8;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_DEQ    = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_AVG    = 2'd3
  } func_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_SCAN,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;       // capture the request
    logic enq;         // write record, bump write pointer and count
    logic scan_start;  // scan index <- read pointer, clear sum
    logic adv;         // advance scan index
    logic acc;         // add read rpm, one entry fewer left
    logic take_rec;    // keep the read record as result, ok
    logic pop;         // drop the oldest entry
    logic div_load;    // start the divider
    logic div_step;    // one quotient bit
    logic set_ok;      // mark the request successful
    logic load_out;    // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  match;
    logic  last;
    logic  div_last;
    logic  out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: hdl/cfsa_if.sv
`default_nettype none

// Request channel
interface cfsa_in_if;
  logic                       valid;
  logic                       ready;
  logic [cfsa_pkg::FUNC_W-1:0]  func;
  logic [cfsa_pkg::TIME_W-1:0]  in_time;
  logic [cfsa_pkg::RPM_W-1:0]   in_rpm;
  logic [cfsa_pkg::OTHER_W-1:0] in_other;

  modport source (output valid, func, in_time, in_rpm, in_other, input ready);
  modport sink   (input valid, func, in_time, in_rpm, in_other, output ready);
endinterface

// Result channel
interface cfsa_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [cfsa_pkg::TIME_W-1:0]  out_time;
  logic [cfsa_pkg::RPM_W-1:0]   out_rpm;
  logic [cfsa_pkg::OTHER_W-1:0] out_other;
  logic [cfsa_pkg::AVG_W-1:0]   avg_rpm;
  logic [cfsa_pkg::FILL_W-1:0]  fill_count;

  modport source (output valid, ok, out_time, out_rpm, out_other, avg_rpm, fill_count,
                  input ready);
  modport sink   (input valid, ok, out_time, out_rpm, out_other, avg_rpm, fill_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/circular_fifo_search_average.sv
// Each request is decoded; for dequeue, search and average the record RAM is then
// walked from the read pointer, one entry per cycle through its read port, with
// search stopping at the first match. An average then runs a serial divider that
// yields 24+log2(DEPTH) quotient bits, one per cycle. On an empty FIFO the walk
// is skipped. One request in flight; a result may wait for out_ch.ready.
// rst_n (synchronous) empties the FIFO and clears pointers; RAM contents are kept.
`default_nettype none

module circular_fifo_search_average #(
  parameter int DEPTH        = cfsa_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = cfsa_pkg::PAYLOAD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cfsa_in_if.sink      in_ch,
  cfsa_out_if.source   out_ch
);

  cfsa_pkg::cmd_t    cmd;
  cfsa_pkg::status_t sts;

  cfsa_ctrl u_cfsa_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfsa_datapath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_cfsa_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_ch.func),
    .in_time   (in_ch.in_time),
    .in_rpm    (in_ch.in_rpm),
    .in_other  (in_ch.in_other),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ok    (out_ch.ok),
    .out_time  (out_ch.out_time),
    .out_rpm   (out_ch.out_rpm),
    .out_other (out_ch.out_other),
    .out_avg   (out_ch.avg_rpm),
    .out_fill  (out_ch.fill_count)
  );

endmodule

`default_nettype wire

FILE: hdl/cfsa_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module cfsa_ram #(
  parameter int WIDTH = cfsa_pkg::TIME_W,
  parameter int DEPTH = cfsa_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hdl/cfsa_ctrl.sv
`default_nettype none

// Request sequencer: decodes the operation and steps the datapath.
module cfsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfsa_pkg::status_t sts,
  output cfsa_pkg::cmd_t    cmd
);

  cfsa_pkg::state_t state_r;
  cfsa_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      cfsa_pkg::ST_IDLE: begin
        // no request taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.latch = 1'b1;
          state_nxt = cfsa_pkg::ST_DECODE;
        end
      end
      cfsa_pkg::ST_DECODE: begin
        if (sts.func == cfsa_pkg::FUNC_ENQ) begin
          cmd.enq   = !sts.full;
          state_nxt = cfsa_pkg::ST_DONE;
        end else if (sts.empty) begin
          state_nxt = cfsa_pkg::ST_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = cfsa_pkg::ST_FILL;
        end
      end
      // first read is in flight
      cfsa_pkg::ST_FILL: begin
        cmd.adv   = 1'b1;
        state_nxt = cfsa_pkg::ST_SCAN;
      end
      cfsa_pkg::ST_SCAN: begin
        case (sts.func)
          cfsa_pkg::FUNC_DEQ: begin
            cmd.take_rec = 1'b1;
            cmd.pop      = 1'b1;
            state_nxt    = cfsa_pkg::ST_DONE;
          end
          cfsa_pkg::FUNC_SEARCH: begin
            if (sts.match) begin
              cmd.take_rec = 1'b1;
              state_nxt    = cfsa_pkg::ST_DONE;
            end else if (sts.last) begin
              state_nxt = cfsa_pkg::ST_DONE;
            end else begin
              cmd.acc = 1'b1;
              cmd.adv = 1'b1;
            end
          end
          cfsa_pkg::FUNC_AVG: begin
            cmd.acc = 1'b1;
            cmd.adv = 1'b1;
            if (sts.last) begin
              state_nxt = cfsa_pkg::ST_DIV_LOAD;
            end
          end
          default: begin
            state_nxt = cfsa_pkg::ST_DONE;
          end
        endcase
      end
      cfsa_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = cfsa_pkg::ST_DIV;
      end
      cfsa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.set_ok = 1'b1;
          state_nxt  = cfsa_pkg::ST_DONE;
        end
      end
      cfsa_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = cfsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/cfsa_datapath.sv
`default_nettype none

// Pointers, record store, scan/sum unit, serial divider and output register.
module cfsa_datapath #(
  parameter int DEPTH        = cfsa_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = cfsa_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfsa_pkg::cmd_t               cmd,
  output cfsa_pkg::status_t            sts,
  // request payload
  input  logic [cfsa_pkg::FUNC_W-1:0]  in_func,
  input  logic [cfsa_pkg::TIME_W-1:0]  in_time,
  input  logic [cfsa_pkg::RPM_W-1:0]   in_rpm,
  input  logic [cfsa_pkg::OTHER_W-1:0] in_other,
  // result side
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [cfsa_pkg::TIME_W-1:0]  out_time,
  output logic [cfsa_pkg::RPM_W-1:0]   out_rpm,
  output logic [cfsa_pkg::OTHER_W-1:0] out_other,
  output logic [cfsa_pkg::AVG_W-1:0]   out_avg,
  output logic [cfsa_pkg::FILL_W-1:0]  out_fill
);

  localparam int TIME_W = cfsa_pkg::TIME_W;
  localparam int RPM_W  = cfsa_pkg::RPM_W;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = RPM_W + PTR_W;
  localparam int DIV_W  = SUM_W + cfsa_pkg::FRAC_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int REC_W  = TIME_W + RPM_W + PAYLOAD_BITS;
  localparam int OX_W   = (PAYLOAD_BITS > cfsa_pkg::OTHER_W) ? PAYLOAD_BITS
                                                             : cfsa_pkg::OTHER_W;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIV_W);

  // request capture
  cfsa_pkg::func_t           func_r;
  logic [TIME_W-1:0]         key_r;
  logic [RPM_W-1:0]          rpm_r;
  logic [PAYLOAD_BITS-1:0]   other_r;
  logic [OX_W-1:0]           other_in_ext;

  // FIFO control
  logic [PTR_W-1:0]          rd_ptr_r;
  logic [PTR_W-1:0]          wr_ptr_r;
  logic [CNT_W-1:0]          cnt_r;

  // scan and sum
  logic [PTR_W-1:0]          scan_idx_r;
  logic [CNT_W-1:0]          left_r;
  logic [SUM_W-1:0]          sum_r;

  // divider
  logic [CNT_W-1:0]          rem_r;
  logic [CNT_W-1:0]          rem_nxt;
  logic [DIV_W-1:0]          dvd_r;
  logic [DIV_W-1:0]          dvd_nxt;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [CNT_W:0]            trial;
  logic                      trial_ge;

  // result being built
  logic                      ok_r;
  logic [TIME_W-1:0]         rec_time_r;
  logic [RPM_W-1:0]          rec_rpm_r;
  logic [PAYLOAD_BITS-1:0]   rec_other_r;
  logic [OX_W-1:0]           rec_other_ext;

  // output register
  logic                           out_valid_r;
  logic                           o_ok_r;
  logic [TIME_W-1:0]              o_time_r;
  logic [RPM_W-1:0]               o_rpm_r;
  logic [cfsa_pkg::OTHER_W-1:0]   o_other_r;
  logic [cfsa_pkg::AVG_W-1:0]     o_avg_r;
  logic [cfsa_pkg::FILL_W-1:0]    o_fill_r;

  // RAM ports
  logic [REC_W-1:0]          wr_data;
  logic [REC_W-1:0]          rd_data;
  logic [TIME_W-1:0]         rd_time;
  logic [RPM_W-1:0]          rd_rpm;
  logic [PAYLOAD_BITS-1:0]   rd_other;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Record store
  assign other_in_ext = OX_W'(in_other);
  assign wr_data      = {key_r, rpm_r, other_r};

  cfsa_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_cfsa_ram (
    .clk     (clk),
    .wr_en   (cmd.enq),
    .wr_addr (wr_ptr_r),
    .wr_data (wr_data),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  assign {rd_time, rd_rpm, rd_other} = rd_data;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= cfsa_pkg::func_t'(in_func);
      key_r   <= in_time;
      rpm_r   <= in_rpm;
      other_r <= other_in_ext[PAYLOAD_BITS-1:0];
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cmd.enq) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
        cnt_r    <= cnt_r + 1'b1;
      end else if (cmd.pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
        cnt_r    <= cnt_r - 1'b1;
      end
    end
  end

  // Scan walk over stored entries, oldest first
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= rd_ptr_r;
      left_r     <= cnt_r;
      sum_r      <= '0;
    end else begin
      if (cmd.adv) begin
        scan_idx_r <= wrap_inc(scan_idx_r);
      end
      if (cmd.acc) begin
        sum_r  <= sum_r + SUM_W'(rd_rpm);
        left_r <= left_r - 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per step; quotient ends up in dvd_r
  assign trial    = {rem_r, dvd_r[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, cnt_r};
  assign rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, cnt_r}) : CNT_W'(trial);
  assign dvd_nxt  = {dvd_r[DIV_W-2:0], trial_ge};

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dvd_r <= '0;
    end else if (cmd.div_load) begin
      dvd_r  <= {sum_r, {cfsa_pkg::FRAC_W{1'b0}}};
      rem_r  <= '0;
      dcnt_r <= DIV_STEPS;
    end else if (cmd.div_step) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // Result record
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ok_r        <= 1'b0;
      rec_time_r  <= '0;
      rec_rpm_r   <= '0;
      rec_other_r <= '0;
    end else begin
      if (cmd.take_rec) begin
        rec_time_r  <= rd_time;
        rec_rpm_r   <= rd_rpm;
        rec_other_r <= rd_other;
      end
      if (cmd.take_rec || cmd.enq || cmd.set_ok) begin
        ok_r <= 1'b1;
      end
    end
  end

  assign rec_other_ext = OX_W'(rec_other_r);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_ok_r    <= ok_r;
      o_time_r  <= rec_time_r;
      o_rpm_r   <= rec_rpm_r;
      o_other_r <= rec_other_ext[cfsa_pkg::OTHER_W-1:0];
      o_avg_r   <= dvd_r[cfsa_pkg::AVG_W-1:0];
      o_fill_r  <= cfsa_pkg::FILL_W'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = o_ok_r;
  assign out_time  = o_time_r;
  assign out_rpm   = o_rpm_r;
  assign out_other = o_other_r;
  assign out_avg   = o_avg_r;
  assign out_fill  = o_fill_r;

  // Status to the sequencer
  assign sts.func     = func_r;
  assign sts.empty    = (cnt_r == '0);
  assign sts.full     = (cnt_r == CNT_FULL);
  assign sts.match    = (rd_time == key_r);
  assign sts.last     = (left_r == CNT_W'(1));
  assign sts.div_last = (dcnt_r == DCNT_W'(1));
  assign sts.out_busy = out_valid_r & ~out_ready;

endmodule

`default_nettype wire

FILE: hdl/cfsa_checker.sv
`default_nettype none
`include "circular_fifo_search_average_macros.svh"

// Port-level checks on the FIFO block.
module cfsa_checker #(
  parameter int DEPTH = cfsa_pkg::DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         ok,
  input logic [cfsa_pkg::TIME_W-1:0]  out_time,
  input logic [cfsa_pkg::RPM_W-1:0]   out_rpm,
  input logic [cfsa_pkg::OTHER_W-1:0] out_other,
  input logic [cfsa_pkg::AVG_W-1:0]   avg_rpm,
  input logic [cfsa_pkg::FILL_W-1:0]  fill_count
);

  // stalled result holds
  `CFSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(ok) && $stable(out_time) && $stable(avg_rpm) && $stable(fill_count))
  // one request at a time
  `CFSA_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)
  // refused or unmatched requests carry all-zero data
  `CFSA_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && !ok, avg_rpm == '0 && out_time == '0 && out_rpm == '0 && out_other == '0)
  // an average never carries a record
  `CFSA_ASSERT_IMPL(a_avg_no_rec, clk, rst_n, out_valid && avg_rpm != '0, ok && out_time == '0 && out_rpm == '0 && out_other == '0)
  // fill count bounded by depth
  `CFSA_ASSERT_IMPL(a_fill_bound, clk, rst_n, out_valid, 32'(fill_count) <= 32'(DEPTH))

endmodule

bind circular_fifo_search_average cfsa_checker #(
  .DEPTH (DEPTH)
) u_cfsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .ok         (out_ch.ok),
  .out_time   (out_ch.out_time),
  .out_rpm    (out_ch.out_rpm),
  .out_other  (out_ch.out_other),
  .avg_rpm    (out_ch.avg_rpm),
  .fill_count (out_ch.fill_count)
);

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int FIFO_DEPTH      = cfsa_pkg::DEPTH_DEF;
  localparam int RANDOM_REQUESTS = 925;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int QUIET_FROM      = 550;
  localparam int QUIET_TO        = 700;
  localparam int IDLE_PCT        = 15;

  typedef struct packed {
    cfsa_pkg::func_t                func;
    logic [cfsa_pkg::TIME_W-1:0]    in_time;
    logic [cfsa_pkg::RPM_W-1:0]     in_rpm;
    logic [cfsa_pkg::OTHER_W-1:0]   in_other;
  } request_t;

  typedef struct packed {
    logic                           ok;
    logic [cfsa_pkg::TIME_W-1:0]    rec_time;
    logic [cfsa_pkg::RPM_W-1:0]     rec_rpm;
    logic [cfsa_pkg::OTHER_W-1:0]   rec_other;
    logic [cfsa_pkg::AVG_W-1:0]     avg_rpm;
    logic [cfsa_pkg::FILL_W-1:0]    fill_count;
  } reply_t;

  typedef struct {
    request_t req;
    bit       hand_typed;
    reply_t   reply;
  } stim_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} traffic_t;

  logic clk = 1'b0;
  logic rst_n;

  cfsa_in_if  req_if ();
  cfsa_out_if rsp_if ();

  circular_fifo_search_average i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the record store
  logic [cfsa_pkg::TIME_W-1:0]  fifo_time  [FIFO_DEPTH];
  logic [cfsa_pkg::RPM_W-1:0]   fifo_rpm   [FIFO_DEPTH];
  logic [cfsa_pkg::OTHER_W-1:0] fifo_other [FIFO_DEPTH];
  int unsigned rd_idx   = 0;
  int unsigned wr_idx   = 0;
  int unsigned n_stored = 0;

  reply_t      replies_due [$];
  stim_row_t   directed_rows [$];
  int unsigned op_tally [4][2];
  int unsigned requests_sent  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          quiet_span     = 1'b0;
  bit          held_off       = 1'b0;

  // Apply one request to the shadow FIFO and return the reply it must give
  function automatic reply_t sensor_fifo_step(request_t req);
    reply_t      rep;
    int unsigned idx;
    int unsigned k;
    logic [31:0] rpm_sum;
    rep     = '0;
    idx     = rd_idx;
    rpm_sum = '0;
    case (req.func)
      cfsa_pkg::FUNC_ENQ: begin
        if (n_stored < FIFO_DEPTH) begin
          fifo_time[wr_idx]  = req.in_time;
          fifo_rpm[wr_idx]   = req.in_rpm;
          fifo_other[wr_idx] = req.in_other;
          wr_idx   = (wr_idx + 1) % FIFO_DEPTH;
          n_stored = n_stored + 1;
          rep.ok   = 1'b1;
        end
      end
      cfsa_pkg::FUNC_DEQ: begin
        if (n_stored != 0) begin
          rep.rec_time  = fifo_time[rd_idx];
          rep.rec_rpm   = fifo_rpm[rd_idx];
          rep.rec_other = fifo_other[rd_idx];
          rd_idx   = (rd_idx + 1) % FIFO_DEPTH;
          n_stored = n_stored - 1;
          rep.ok   = 1'b1;
        end
      end
      cfsa_pkg::FUNC_SEARCH: begin
        // oldest match wins
        for (k = 0; k < n_stored; k++) begin
          if (!rep.ok && fifo_time[idx] == req.in_time) begin
            rep.rec_time  = fifo_time[idx];
            rep.rec_rpm   = fifo_rpm[idx];
            rep.rec_other = fifo_other[idx];
            rep.ok        = 1'b1;
          end
          idx = (idx + 1) % FIFO_DEPTH;
        end
      end
      default: begin
        // mean in U16.8, truncated
        if (n_stored != 0) begin
          for (k = 0; k < n_stored; k++) begin
            rpm_sum = rpm_sum + fifo_rpm[idx];
            idx     = (idx + 1) % FIFO_DEPTH;
          end
          rep.avg_rpm = cfsa_pkg::AVG_W'((rpm_sum << cfsa_pkg::FRAC_W) / n_stored);
          rep.ok      = 1'b1;
        end
      end
    endcase
    rep.fill_count = cfsa_pkg::FILL_W'(n_stored);
    op_tally[req.func][rep.ok]++;
    return rep;
  endfunction

  task automatic add_row(cfsa_pkg::func_t f, logic [cfsa_pkg::TIME_W-1:0] t,
                         logic [cfsa_pkg::RPM_W-1:0] r, logic [cfsa_pkg::OTHER_W-1:0] o,
                         bit hand_typed, reply_t rep = '0);
    stim_row_t row;
    row.req        = '{f, t, r, o};
    row.hand_typed = hand_typed;
    row.reply      = rep;
    directed_rows.push_back(row);
  endtask

  // Offer one request with random idle cycles ahead of it; wait for acceptance
  task automatic send_request(request_t req, bit hand_typed, reply_t typed_reply);
    reply_t due;
    quiet_span = (requests_sent >= QUIET_FROM && requests_sent < QUIET_TO);
    while (!quiet_span && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.func     <= req.func;
    req_if.in_time  <= req.in_time;
    req_if.in_rpm   <= req.in_rpm;
    req_if.in_other <= req.in_other;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    due = sensor_fifo_step(req);
    if (hand_typed) due = typed_reply;
    replies_due.push_back(due);
    requests_sent++;
  endtask

  task automatic log_mismatch(string what, reply_t want, reply_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: want ok=%0b t=%h rpm=%h oth=%h avg=%h fill=%0d",
               $realtime, what, want.ok, want.rec_time, want.rec_rpm, want.rec_other,
               want.avg_rpm, want.fill_count);
    if (mismatch_count <= 10)
      $display("    got ok=%0b t=%h rpm=%h oth=%h avg=%h fill=%0d",
               got.ok, got.rec_time, got.rec_rpm, got.rec_other, got.avg_rpm,
               got.fill_count);
  endtask

  // Result side: random stalls, one long hold-off, a stretch with none
  initial begin
    forever begin
      if (!held_off && requests_sent >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          rsp_if.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        rsp_if.ready <= quiet_span || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  // Compare each reply with the oldest one due
  always @(posedge clk) begin : reply_check
    reply_t got;
    reply_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.ok, rsp_if.out_time, rsp_if.out_rpm, rsp_if.out_other,
              rsp_if.avg_rpm, rsp_if.fill_count};
      if (replies_due.size() == 0) begin
        log_mismatch("reply with no request pending", '0, got);
      end else begin
        want = replies_due.pop_front();
        if (got.ok !== want.ok || got.rec_time !== want.rec_time ||
            got.rec_rpm !== want.rec_rpm || got.rec_other !== want.rec_other ||
            got.avg_rpm !== want.avg_rpm || got.fill_count !== want.fill_count)
          log_mismatch("reply mismatch", want, got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, replies_due.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    request_t    req;
    traffic_t    phase;
    int          phase_left;
    int          enq_pct;
    int          deq_pct;
    int          roll;
    int          n;
    int          k;
    phase      = PH_FILL;
    phase_left = 0;

    req_if.valid    <= 1'b0;
    req_if.func     <= cfsa_pkg::FUNC_ENQ;
    req_if.in_time  <= '0;
    req_if.in_rpm   <= '0;
    req_if.in_other <= '0;
    rst_n           <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty cases, extremes, duplicates, full
    add_row(cfsa_pkg::FUNC_DEQ,    '0, '0, '0, 1, '{1'b0, '0, '0, '0, '0, 5'd0});
    add_row(cfsa_pkg::FUNC_SEARCH, '0, '0, '0, 1, '{1'b0, '0, '0, '0, '0, 5'd0});
    add_row(cfsa_pkg::FUNC_AVG,    '0, '0, '0, 1, '{1'b0, '0, '0, '0, '0, 5'd0});
    add_row(cfsa_pkg::FUNC_ENQ,    '0, '0, '0, 1, '{1'b1, '0, '0, '0, '0, 5'd1});
    add_row(cfsa_pkg::FUNC_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1,
            '{1'b1, '0, '0, '0, '0, 5'd2});
    add_row(cfsa_pkg::FUNC_AVG, '0, '0, '0, 1, '{1'b1, '0, '0, '0, 24'h7F_FF80, 5'd2});
    add_row(cfsa_pkg::FUNC_SEARCH, 32'hFFFF_FFFF, '0, '0, 1,
            '{1'b1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, '0, 5'd2});
    add_row(cfsa_pkg::FUNC_SEARCH, 32'hDEAD_BEEF, '0, '0, 1,
            '{1'b0, '0, '0, '0, '0, 5'd2});
    for (k = 0; k < FIFO_DEPTH - 2; k++)
      add_row(cfsa_pkg::FUNC_ENQ, (k % 3 == 0) ? 32'h55 : 32'(32'h1000 + k),
              16'(16'hFFFF - k), 32'(32'hA5A5_0000 | k), 0);
    add_row(cfsa_pkg::FUNC_ENQ, 32'h1234_5678, 16'h4321, 32'h0F0F_0F0F, 1,
            '{1'b0, '0, '0, '0, '0, 5'd16});
    add_row(cfsa_pkg::FUNC_SEARCH, 32'h55, '0, '0, 0);
    add_row(cfsa_pkg::FUNC_AVG, '0, '0, '0, 0);
    add_row(cfsa_pkg::FUNC_DEQ, '0, '0, '0, 1, '{1'b1, '0, '0, '0, '0, 5'd15});

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].hand_typed,
                   directed_rows[i].reply);

    // Random traffic in fill, drain and mixed phases
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        phase      = traffic_t'($urandom_range(2));
        phase_left = $urandom_range(30, 60);
      end
      phase_left--;
      case (phase)
        PH_FILL: begin
          enq_pct = 65;
          deq_pct = 10;
        end
        PH_DRAIN: begin
          enq_pct = 10;
          deq_pct = 65;
        end
        default: begin
          enq_pct = 30;
          deq_pct = 30;
        end
      endcase
      roll = $urandom_range(99);
      if (roll < enq_pct)
        req.func = cfsa_pkg::FUNC_ENQ;
      else if (roll < enq_pct + deq_pct)
        req.func = cfsa_pkg::FUNC_DEQ;
      else
        req.func = $urandom_range(1) ? cfsa_pkg::FUNC_SEARCH : cfsa_pkg::FUNC_AVG;

      // narrow timestamps give duplicate keys
      req.in_time = $urandom_range(1) ? 32'($urandom_range(15)) : 32'($urandom());
      if (req.func == cfsa_pkg::FUNC_SEARCH && n_stored != 0 && $urandom_range(99) < 60)
        req.in_time = fifo_time[(rd_idx + $urandom_range(n_stored - 1)) % FIFO_DEPTH];
      case ($urandom_range(9))
        0:       req.in_rpm = '0;
        1:       req.in_rpm = 16'hFFFF;
        default: req.in_rpm = 16'($urandom());
      endcase
      req.in_other = $urandom();
      send_request(req, 0, '0);
    end
    req_if.valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: enqueue %0d/%0d refused, dequeue %0d/%0d refused,",
             requests_sent, op_tally[cfsa_pkg::FUNC_ENQ][1],
             op_tally[cfsa_pkg::FUNC_ENQ][0], op_tally[cfsa_pkg::FUNC_DEQ][1],
             op_tally[cfsa_pkg::FUNC_DEQ][0]);
    $display("  search %0d hit/%0d miss, average %0d/%0d empty, %0d mismatches",
             op_tally[cfsa_pkg::FUNC_SEARCH][1], op_tally[cfsa_pkg::FUNC_SEARCH][0],
             op_tally[cfsa_pkg::FUNC_AVG][1], op_tally[cfsa_pkg::FUNC_AVG][0],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
